/* design/mkhe_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mkhe_pkg
// Shared constants for the map key hash engine: key kind codes and the
// multipliers used by the mix step and the string update.
// ---------------------------------------------------------------------------
package mkhe_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned FUNC_W = 4;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned MAX_WORDS = 4;
    localparam int unsigned CNT_W = 3;

    localparam logic [WORD_W-1:0] MIX_MULT = 32'h85eb_ca6b;
    localparam logic [WORD_W-1:0] STR_MULT = 32'd31;
    localparam int unsigned MIX_SHIFT_A = 16;
    localparam int unsigned MIX_SHIFT_B = 13;

    localparam logic [FUNC_W-1:0] FUNC_EMPTY = 4'd0;
    localparam logic [FUNC_W-1:0] FUNC_BYTE  = 4'd1;
    localparam logic [FUNC_W-1:0] FUNC_HALF  = 4'd2;
    localparam logic [FUNC_W-1:0] FUNC_WORD  = 4'd3;
    localparam logic [FUNC_W-1:0] FUNC_DWORD = 4'd4;
    localparam logic [FUNC_W-1:0] FUNC_QWORD = 4'd5;
    localparam logic [FUNC_W-1:0] FUNC_F32   = 4'd6;
    localparam logic [FUNC_W-1:0] FUNC_F64   = 4'd7;
    localparam logic [FUNC_W-1:0] FUNC_TEXT  = 4'd8;

    typedef logic [WORD_W-1:0] word_t;

endpackage

/* design/map_key_hash_engine_unit.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// map_key_hash_engine_unit
// Hashes one map key per input beat to 32 bits under the beat's seed.
//
// Input channel s_*: one key per beat, s_func selects the key kind. A string
// streams one byte per beat (kind 8), framed by s_text_first/s_text_last;
// s_text_empty hashes a zero-length string. Output channel m_*: one hash
// beat per fixed-width key, per last string byte and per empty string.
// A non-last string byte and the unused kinds 9 to 15 give no output beat.
// Each mix step uses the shared mix multiplier in ST_MUL, then ST_FIN.
// Narrow keys, strings and zero f64 keys need the fewest steps, dword and
// other f64 keys more, 128-bit keys the most; ST_DONE then loads the output
// register. The next key is taken only after the sequencer is idle again.
// A non-last string byte is absorbed in its accept cycle.
// s_ready is high only while the sequencer is idle; one key at a time.
// A finished hash waits in the output register while the next key is taken;
// a stalled receiver holds the sequencer once a second hash is ready.
// Reset (aresetn low, synchronous) empties the output register, returns the
// sequencer to idle and clears the running string hash to zero.
// ---------------------------------------------------------------------------
module map_key_hash_engine_unit
    import mkhe_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [FUNC_W-1:0]     s_func,
    input  logic [WORD_W-1:0]     s_seed,
    input  logic [2*WORD_W-1:0]   s_key_low,
    input  logic [2*WORD_W-1:0]   s_key_high,
    input  logic [BYTE_W-1:0]     s_text_byte,
    input  logic                  s_text_first,
    input  logic                  s_text_last,
    input  logic                  s_text_empty,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [WORD_W-1:0]     m_hash
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_FIN,
        ST_DONE
    } state_t;

    state_t                        state_reg, state_next;
    word_t                         h_reg, h_next;
    logic [MAX_WORDS*WORD_W-1:0]   words_reg, words_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    word_t                         running_reg, running_next;
    logic                          m_valid_reg, m_valid_next;
    word_t                         hash_reg, hash_next;

    logic   accept;
    word_t  w0;
    word_t  text_base;
    word_t  text_sum;
    word_t  mix_out;
    logic   mix_load;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_hash   = hash_reg;
    assign w0       = s_key_low[WORD_W-1:0];
    assign mix_load = (state_reg == ST_MUL);

    assign text_base = s_text_first ? s_seed : running_reg;
    assign text_sum  = WORD_W'(text_base * STR_MULT) + WORD_W'(s_text_byte);

    mkhe_mixer u_mixer (
        .aclk    (aclk),
        .load    (mix_load),
        .mix_in  (h_reg ^ words_reg[WORD_W-1:0]),
        .mix_out (mix_out)
    );

    always_comb begin
        state_next   = state_reg;
        h_next       = h_reg;
        words_next   = words_reg;
        count_next   = count_reg;
        running_next = running_reg;
        m_valid_next = m_valid_reg;
        hash_next    = hash_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    h_next     = s_seed;
                    words_next = '0;
                    count_next = CNT_W'(1);
                    state_next = ST_MUL;
                    case (s_func)
                        FUNC_EMPTY: ;
                        FUNC_BYTE: words_next[WORD_W-1:0] = {24'd0, w0[7:0]};
                        FUNC_HALF: words_next[WORD_W-1:0] = {16'd0, w0[15:0]};
                        FUNC_WORD: words_next[WORD_W-1:0] = w0;
                        FUNC_DWORD: begin
                            words_next[2*WORD_W-1:0] = s_key_low;
                            count_next = CNT_W'(2);
                        end
                        FUNC_QWORD: begin
                            words_next = {s_key_high, s_key_low};
                            count_next = CNT_W'(MAX_WORDS);
                        end
                        FUNC_F32: begin
                            if (w0[WORD_W-2:0] != '0) begin
                                words_next[WORD_W-1:0] = w0;
                            end
                        end
                        FUNC_F64: begin
                            if (s_key_low[2*WORD_W-2:0] != '0) begin
                                words_next[2*WORD_W-1:0] = s_key_low;
                                count_next = CNT_W'(2);
                            end
                        end
                        FUNC_TEXT: begin
                            if (s_text_empty) begin
                                running_next = s_seed;
                            end else begin
                                running_next = text_sum;
                                h_next       = text_sum;
                                if (!s_text_last) begin
                                    state_next = ST_IDLE;
                                end
                            end
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_MUL: begin
                state_next = ST_FIN;
            end
            ST_FIN: begin
                h_next     = mix_out;
                words_next = words_reg >> WORD_W;
                count_next = count_reg - CNT_W'(1);
                state_next = (count_reg == CNT_W'(1)) ? ST_DONE : ST_MUL;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    hash_next    = h_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            running_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            running_reg <= running_next;
            m_valid_reg <= m_valid_next;
            h_reg       <= h_next;
            words_reg   <= words_next;
            hash_reg    <= hash_next;
        end
    end

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_WORDS))
        else $error("mix step count out of range");

    a_mul_then_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_MUL |=> state_reg == ST_FIN)
        else $error("multiply not followed by finish step");

    a_unused_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_func > FUNC_TEXT |=> state_reg == ST_IDLE && !$rose(m_valid_reg))
        else $error("unused key kind started work");

    a_done_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DONE && !m_valid_reg |=> m_valid_reg && state_reg == ST_IDLE)
        else $error("finished hash not loaded into free output register");

endmodule

/* design/mkhe_mixer.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mkhe_mixer
// Shared mix unit: xor-shift, registered 32-bit multiply by the mix
// constant, then the closing xor-shift on the registered product.
// ---------------------------------------------------------------------------
module mkhe_mixer
    import mkhe_pkg::*;
(
    input  logic  aclk,
    input  logic  load,
    input  word_t mix_in,
    output word_t mix_out
);

    word_t pre;
    word_t prod_reg;
    word_t prod_next;

    assign pre       = mix_in ^ (mix_in >> MIX_SHIFT_A);
    assign prod_next = WORD_W'(pre * MIX_MULT);
    assign mix_out   = prod_reg ^ (prod_reg >> MIX_SHIFT_B);

    always_ff @(posedge aclk) begin
        if (load) begin
            prod_reg <= prod_next;
        end
    end

endmodule
